[hw/rtl/fras_pkg.sv]
// Shared types, codes and defaults for the framed register access slave.
`default_nettype none
package fras_pkg;

  localparam int CHUNK_DEPTH_DEF    = 64;
  localparam int MAX_READ_COUNT_DEF = 22;
  localparam int NUM_REGS_DEF       = 32;

  localparam logic [7:0] DEVICE_ID_RST = 8'd11;
  localparam logic [7:0] SYM_START     = 8'h3C;
  localparam logic [7:0] SYM_END       = 8'h3E;
  localparam logic [7:0] CMD_READ_RO   = 8'h01;
  localparam logic [7:0] CMD_READ_RW   = 8'h02;
  localparam logic [7:0] CMD_WRITE_RW  = 8'h03;
  localparam logic [7:0] WRITE_BCNT    = 8'd2;

  // Item kinds on tuser
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_RO_LOAD = 2'd2;

  // Header byte places after the start marker
  localparam int HDR_ID    = 0;
  localparam int HDR_CMD   = 1;
  localparam int HDR_ADDR  = 2;
  localparam int HDR_COUNT = 3;
  localparam int HDR_WHI   = 4;
  localparam int HDR_WLO   = 5;
  localparam int HDR_LEN   = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_CHECK,
    ST_HEAD,
    ST_WORD_RD,
    ST_WORD_WAIT,
    ST_HI,
    ST_LO,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_HI,
    SEL_LO,
    SEL_END
  } sel_t;

  typedef struct packed {
    logic in_rdy;
    logic hdr_step;
    logic do_write;
    logic emit;
    sel_t emit_sel;
    logic word_rd;
    logic word_latch;
    logic chunk_clr;
  } ctl_t;

  typedef struct packed {
    logic end_item;
    logic hdr_done;
    logic frame_ok;
    logic is_read;
    logic is_write;
    logic head_last;
    logic words_left;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[hw/rtl/fras_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fras_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                        wdata,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/fras_ctrl.sv]
// Controller state machine: sequences header fetch, checks and answer bytes.
`default_nettype none
module fras_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  fras_pkg::sts_t   sts,
  output fras_pkg::ctl_t   ctl
);
  import fras_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (sts.end_item) state_nxt = ST_HDR;
      end
      ST_HDR: begin
        if (sts.hdr_done) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.frame_ok && (sts.is_read || sts.is_write)) state_nxt = ST_HEAD;
        else state_nxt = ST_IDLE;
      end
      ST_HEAD: begin
        if (sts.out_free && sts.head_last) state_nxt = ST_WORD_RD;
      end
      ST_WORD_RD: begin
        if (!sts.words_left) state_nxt = ST_END;
        else if (sts.is_write) state_nxt = ST_HI;
        else state_nxt = ST_WORD_WAIT;
      end
      ST_WORD_WAIT: state_nxt = ST_HI;
      ST_HI: begin
        if (sts.out_free) state_nxt = ST_LO;
      end
      ST_LO: begin
        if (sts.out_free) state_nxt = ST_WORD_RD;
      end
      ST_END: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.emit_sel = SEL_HEAD;
    case (state_r)
      ST_IDLE: ctl.in_rdy = 1'b1;
      ST_HDR: ctl.hdr_step = 1'b1;
      ST_CHECK: begin
        if (sts.frame_ok && sts.is_write) ctl.do_write = 1'b1;
        if (!(sts.frame_ok && (sts.is_read || sts.is_write))) ctl.chunk_clr = 1'b1;
      end
      ST_HEAD: begin
        ctl.emit     = sts.out_free;
        ctl.emit_sel = SEL_HEAD;
      end
      ST_WORD_RD: begin
        ctl.word_rd = sts.words_left && !sts.is_write;
      end
      ST_WORD_WAIT: ctl.word_latch = 1'b1;
      ST_HI: begin
        ctl.emit     = sts.out_free;
        ctl.emit_sel = SEL_HI;
      end
      ST_LO: begin
        ctl.emit     = sts.out_free;
        ctl.emit_sel = SEL_LO;
      end
      ST_END: begin
        ctl.emit      = sts.out_free;
        ctl.emit_sel  = SEL_END;
        ctl.chunk_clr = sts.out_free;
      end
      default: ctl = '0;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/fras_dp.sv]
// Datapath: chunk buffer, register files, header capture and output register.
`default_nettype none
module fras_dp #(
  parameter int CHUNK_DEPTH    = fras_pkg::CHUNK_DEPTH_DEF,
  parameter int MAX_READ_COUNT = fras_pkg::MAX_READ_COUNT_DEF,
  parameter int NUM_REGS       = fras_pkg::NUM_REGS_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_tvalid,
  input  wire  [31:0]     in_tdata,
  input  wire  [1:0]      in_tuser,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire             out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  input  wire             cfg_we,
  input  wire  [7:0]      cfg_wdata,
  input  fras_pkg::ctl_t  ctl,
  output fras_pkg::sts_t  sts
);
  import fras_pkg::*;

  localparam int CAW = $clog2(CHUNK_DEPTH);
  localparam int FPW = $clog2(CHUNK_DEPTH + 1);
  localparam int HPW = FPW + 1;
  localparam int RAW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int JW  = $clog2(MAX_READ_COUNT + 2);

  logic        accept;
  logic [7:0]  rx_byte;
  logic [4:0]  ro_index;
  logic [15:0] ro_value;

  assign in_tready = ctl.in_rdy;
  assign accept    = in_tvalid && ctl.in_rdy;
  assign rx_byte   = in_tdata[7:0];
  assign ro_index  = in_tdata[12:8];
  assign ro_value  = in_tdata[28:13];

  // Device id
  logic [7:0] device_id_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= DEVICE_ID_RST;
    end else if (cfg_we) begin
      device_id_r <= cfg_wdata;
    end
  end

  // Chunk gathering
  logic [FPW-1:0] fill_r, start_r, end_r;
  logic           end_seen_r;
  logic           chunk_we;
  logic [CHUNK_DEPTH-1:0] chunk_vld_r;

  assign chunk_we = accept && (in_tuser == KIND_BYTE) && (fill_r < FPW'(CHUNK_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      start_r     <= '0;
      end_r       <= '0;
      end_seen_r  <= 1'b0;
      chunk_vld_r <= '0;
    end else if (ctl.chunk_clr) begin
      fill_r     <= '0;
      start_r    <= '0;
      end_r      <= '0;
      end_seen_r <= 1'b0;
    end else if (chunk_we) begin
      chunk_vld_r[fill_r[CAW-1:0]] <= 1'b1;
      if (rx_byte == SYM_START) start_r <= fill_r + FPW'(1);
      if (rx_byte == SYM_END && fill_r != '0) begin
        end_r      <= fill_r - FPW'(1);
        end_seen_r <= 1'b1;
      end
      fill_r <= fill_r + FPW'(1);
    end
  end

  // Header fetch: issue a read per step, capture one step later
  logic [2:0]     hdr_k_r;
  logic [HPW-1:0] hdr_pos;
  logic           chunk_ok_r;
  logic [7:0]     chunk_rdata;
  logic [7:0]     hdr_r [HDR_LEN];

  assign hdr_pos = {1'b0, start_r} + HPW'(hdr_k_r);

  fras_ram #(.WIDTH(8), .DEPTH(CHUNK_DEPTH)) u_chunk_ram (
    .clk   (clk),
    .we    (chunk_we),
    .waddr (fill_r[CAW-1:0]),
    .wdata (rx_byte),
    .raddr (hdr_pos[CAW-1:0]),
    .rdata (chunk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_k_r <= '0;
    end else if (accept && in_tuser == KIND_END) begin
      hdr_k_r <= '0;
    end else if (ctl.hdr_step && hdr_k_r != 3'(HDR_LEN)) begin
      hdr_k_r <= hdr_k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    chunk_ok_r <= (hdr_pos < HPW'(CHUNK_DEPTH)) && chunk_vld_r[hdr_pos[CAW-1:0]];
    if (ctl.hdr_step && hdr_k_r != 3'd0) begin
      hdr_r[hdr_k_r - 3'd1] <= chunk_ok_r ? chunk_rdata : 8'h00;
    end
  end

  logic [7:0] cmd, addr, count, bcnt;
  assign cmd   = hdr_r[HDR_CMD];
  assign addr  = hdr_r[HDR_ADDR];
  assign count = hdr_r[HDR_COUNT];
  assign bcnt  = sts.is_write ? WRITE_BCNT : {count[6:0], 1'b0};

  // Register files
  logic [NUM_REGS-1:0] rw_vld_r, ro_vld_r;
  logic        ro_we, rw_we, addr_in;
  logic [RAW-1:0] ro_waddr, rd_addr;
  logic [8:0]  rd_sum;
  logic [JW-1:0] word_j_r;
  logic [15:0] ro_rdata, rw_rdata, wdata, word_r;
  logic        ro_ok_r, rw_ok_r, sel_ro_r;

  assign ro_we    = accept && (in_tuser == KIND_RO_LOAD) && ({4'd0, ro_index} < 9'(NUM_REGS));
  assign ro_waddr = RAW'(ro_index);
  assign addr_in  = {1'b0, addr} < 9'(NUM_REGS);
  assign wdata    = {hdr_r[HDR_WHI], hdr_r[HDR_WLO]};
  assign rw_we    = ctl.do_write && addr_in;
  assign rd_sum   = {1'b0, addr} + 9'(word_j_r);
  assign rd_addr  = RAW'(rd_sum);

  fras_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_ro_ram (
    .clk   (clk),
    .we    (ro_we),
    .waddr (ro_waddr),
    .wdata (ro_value),
    .raddr (rd_addr),
    .rdata (ro_rdata)
  );

  fras_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_rw_ram (
    .clk   (clk),
    .we    (rw_we),
    .waddr (RAW'(addr)),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rw_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rw_vld_r <= '0;
      ro_vld_r <= '0;
    end else begin
      if (ro_we) ro_vld_r[ro_waddr] <= 1'b1;
      if (rw_we) rw_vld_r[RAW'(addr)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.word_rd) begin
      sel_ro_r <= (cmd == CMD_READ_RO);
      ro_ok_r  <= (rd_sum < 9'(NUM_REGS)) && ro_vld_r[rd_addr];
      rw_ok_r  <= (rd_sum < 9'(NUM_REGS)) && rw_vld_r[rd_addr];
    end
    if (ctl.do_write) begin
      word_r <= addr_in ? wdata : 16'h0000;
    end else if (ctl.word_latch) begin
      if (sel_ro_r) word_r <= ro_ok_r ? ro_rdata : 16'h0000;
      else          word_r <= rw_ok_r ? rw_rdata : 16'h0000;
    end
  end

  // Answer counters
  logic [2:0] head_h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_h_r <= '0;
      word_j_r <= '0;
    end else if (accept && in_tuser == KIND_END) begin
      head_h_r <= '0;
      word_j_r <= '0;
    end else if (ctl.emit) begin
      if (ctl.emit_sel == SEL_HEAD) head_h_r <= head_h_r + 3'd1;
      if (ctl.emit_sel == SEL_LO)   word_j_r <= word_j_r + JW'(1);
    end
  end

  // Output register
  logic       out_valid_r, out_last_r;
  logic [7:0] out_byte_r, emit_byte;

  always_comb begin
    emit_byte = SYM_END;
    case (ctl.emit_sel)
      SEL_HEAD: begin
        case (head_h_r)
          3'd0:    emit_byte = SYM_START;
          3'd1:    emit_byte = device_id_r;
          3'd2:    emit_byte = cmd;
          3'd3:    emit_byte = addr;
          default: emit_byte = bcnt;
        endcase
      end
      SEL_HI:  emit_byte = word_r[15:8];
      SEL_LO:  emit_byte = word_r[7:0];
      SEL_END: emit_byte = SYM_END;
      default: emit_byte = SYM_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= (ctl.emit_sel == SEL_END);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  // Status
  always_comb begin
    sts.end_item   = accept && (in_tuser == KIND_END);
    sts.hdr_done   = (hdr_k_r == 3'(HDR_LEN));
    sts.frame_ok   = end_seen_r && (start_r < end_r) && (hdr_r[HDR_ID] == device_id_r);
    sts.is_read    = (cmd == CMD_READ_RO || cmd == CMD_READ_RW) &&
                     (count <= 8'(MAX_READ_COUNT));
    sts.is_write   = (cmd == CMD_WRITE_RW);
    sts.head_last  = (head_h_r == 3'd4);
    sts.words_left = sts.is_write ? (word_j_r == '0) : ({{(8-JW){1'b0}}, word_j_r} < count);
    sts.out_free   = !out_valid_r || out_tready;
  end

endmodule
`default_nettype wire

[hw/rtl/framed_register_access_slave_core.sv]
// Top level of the framed register access slave: controller plus datapath.
//
//   Channel | Direction | Ports                       | Contents
//   in      | slave     | in_tvalid/tready/tdata/user | byte, end of chunk, read-only load
//   out     | master    | out_tvalid/tready/tdata/last| answer frame bytes
//   cfg     | write     | cfg_we/cfg_wdata            | device id
//
// A byte or load transaction is accepted in the idle state. An end-of-chunk
// transaction runs header fetch and check, then emits the answer bytes, with
// a register file read per read word and one closing word check (two word
// checks for a write), plus any output stall.
// Input is held off until the closing byte has entered the output register.
// Reset clears the chunk valid bits and both register files' valid bits at once.
`default_nettype none
module framed_register_access_slave_core #(
  parameter int CHUNK_DEPTH    = fras_pkg::CHUNK_DEPTH_DEF,
  parameter int MAX_READ_COUNT = fras_pkg::MAX_READ_COUNT_DEF,
  parameter int NUM_REGS       = fras_pkg::NUM_REGS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // rx_byte[7:0], ro_index[12:8], ro_value[28:13], zeros
  input  wire  [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // tx_byte[7:0]
  output logic        out_tlast,
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata
);
  import fras_pkg::*;

  ctl_t ctl;
  sts_t sts;

  fras_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  fras_dp #(
    .CHUNK_DEPTH    (CHUNK_DEPTH),
    .MAX_READ_COUNT (MAX_READ_COUNT),
    .NUM_REGS       (NUM_REGS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ctl        (ctl),
    .sts        (sts)
  );

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the framed register access slave core.
module tb;
  import fras_pkg::*;

  localparam int DEPTH    = CHUNK_DEPTH_DEF;
  localparam int MAXCNT   = MAX_READ_COUNT_DEF;
  localparam int NREGS    = NUM_REGS_DEF;
  localparam int WD_LIMIT = 3000;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  rx;
    logic [4:0]  idx;
    logic [15:0] val;
  } rx_item_t;

  typedef struct {
    logic [7:0] tx;
    logic       last;
  } tx_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  framed_register_access_slave_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow state of the slave
  logic [7:0]  sh_id;
  logic [7:0]  sh_id_next;
  logic [7:0]  sh_chunk [DEPTH];
  int unsigned sh_fill, sh_start, sh_end;
  bit          sh_end_seen;
  logic [15:0] sh_rw [NREGS];
  logic [15:0] sh_ro [NREGS];

  rx_item_t pending_items[$];
  tx_byte_t answer_bytes[$];
  rx_item_t cur;
  int       in_gap, out_gap, holdoff_left;
  bit       holdoff_done;
  int       mismatches, out_count, frames_seen, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] chunk_at(int unsigned pos);
    if (pos < DEPTH) return sh_chunk[pos];
    return 8'd0;
  endfunction

  function automatic logic [15:0] reg_at(bit ro, int unsigned a);
    if (a >= NREGS) return 16'd0;
    return ro ? sh_ro[a] : sh_rw[a];
  endfunction

  function automatic void queue_tx(logic [7:0] b, logic l);
    tx_byte_t t;
    t.tx = b;
    t.last = l;
    answer_bytes.push_back(t);
  endfunction

  function automatic void build_answer();
    logic [7:0]  cmd, addr, cnt;
    logic [15:0] wv, v;
    if (!sh_end_seen || !(sh_start < sh_end)) return;
    if (chunk_at(sh_start + HDR_ID) != sh_id) return;
    cmd  = chunk_at(sh_start + HDR_CMD);
    addr = chunk_at(sh_start + HDR_ADDR);
    cnt  = chunk_at(sh_start + HDR_COUNT);
    wv   = {chunk_at(sh_start + HDR_WHI), chunk_at(sh_start + HDR_WLO)};
    if (cmd == CMD_READ_RO || cmd == CMD_READ_RW) begin
      if (cnt > MAXCNT) return;
      queue_tx(SYM_START, 1'b0);
      queue_tx(sh_id, 1'b0);
      queue_tx(cmd, 1'b0);
      queue_tx(addr, 1'b0);
      queue_tx(8'(cnt * 2), 1'b0);
      for (int j = 0; j < cnt; j++) begin
        v = reg_at(cmd == CMD_READ_RO, addr + j);
        queue_tx(v[15:8], 1'b0);
        queue_tx(v[7:0], 1'b0);
      end
      queue_tx(SYM_END, 1'b1);
      frames_seen++;
    end else if (cmd == CMD_WRITE_RW) begin
      if (addr < NREGS) sh_rw[addr] = wv;
      v = reg_at(1'b0, addr);
      queue_tx(SYM_START, 1'b0);
      queue_tx(sh_id, 1'b0);
      queue_tx(cmd, 1'b0);
      queue_tx(addr, 1'b0);
      queue_tx(WRITE_BCNT, 1'b0);
      queue_tx(v[15:8], 1'b0);
      queue_tx(v[7:0], 1'b0);
      queue_tx(SYM_END, 1'b1);
      frames_seen++;
    end
  endfunction

  function automatic void absorb_item(rx_item_t it);
    case (it.kind)
      KIND_BYTE: begin
        if (sh_fill < DEPTH) begin
          sh_chunk[sh_fill] = it.rx;
          if (it.rx == SYM_START) sh_start = sh_fill + 1;
          if (it.rx == SYM_END && sh_fill > 0) begin
            sh_end = sh_fill - 1;
            sh_end_seen = 1'b1;
          end
          sh_fill++;
        end
      end
      KIND_END: begin
        build_answer();
        sh_fill = 0;
        sh_start = 0;
        sh_end = 0;
        sh_end_seen = 1'b0;
      end
      KIND_RO_LOAD: if (it.idx < NREGS) sh_ro[it.idx] = it.val;
      default: ;
    endcase
  endfunction

  // Stimulus builders
  task automatic push_raw(logic [1:0] k, logic [7:0] b, logic [4:0] i, logic [15:0] v);
    rx_item_t it;
    it.kind = k;
    it.rx = b;
    it.idx = i;
    it.val = v;
    pending_items.push_back(it);
  endtask

  task automatic push_byte(logic [7:0] b);
    push_raw(KIND_BYTE, b, 5'($urandom), 16'($urandom));
  endtask

  task automatic push_end();
    push_raw(KIND_END, 8'($urandom), 5'($urandom), 16'($urandom));
  endtask

  task automatic push_frame(logic [7:0] id, logic [7:0] cmd, logic [7:0] addr,
                            logic [7:0] cnt, logic [15:0] wv);
    push_byte(SYM_START);
    push_byte(id);
    push_byte(cmd);
    push_byte(addr);
    push_byte(cnt);
    push_byte(wv[15:8]);
    push_byte(wv[7:0]);
    push_byte(SYM_END);
    push_end();
  endtask

  task automatic random_phase(int n);
    int r, base;
    logic [7:0] cmd, cnt;
    base = pending_items.size();
    while (pending_items.size() - base < n) begin
      r = $urandom_range(0, 19);
      if (r < 13) begin
        case ($urandom_range(0, 9))
          0, 1, 2: cmd = CMD_READ_RO;
          3, 4, 5: cmd = CMD_READ_RW;
          6, 7, 8: cmd = CMD_WRITE_RW;
          default: cmd = 8'($urandom);
        endcase
        cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        if ($urandom_range(0, 3) == 0) push_byte(8'($urandom));
        push_frame(($urandom_range(0, 7) == 0) ? 8'($urandom) : sh_id_next, cmd,
                   ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 35)),
                   cnt, 16'($urandom));
      end else if (r < 16) begin
        push_raw(KIND_RO_LOAD, 8'($urandom), 5'($urandom), 16'($urandom));
      end else if (r < 18) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        if ($urandom_range(0, 1)) push_end();
      end else if (r < 19) begin
        push_raw(2'd3, 8'($urandom), 5'($urandom), 16'($urandom));
      end else begin
        push_byte(SYM_START);
        push_byte(sh_id_next);
        push_byte(SYM_END);
        push_end();
      end
    end
  endtask

  task automatic settle_and_config(logic [7:0] id);
    while (pending_items.size() != 0 || in_tvalid || answer_bytes.size() != 0)
      @(posedge clk);
    // leave room for a silent end-of-chunk still being checked
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= id;
    sh_id = id;
    sh_id_next = id;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver
  always @(posedge clk) begin
    bit nv;
    if (rst_n) begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        absorb_item(cur);
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          cur = pending_items.pop_front();
          in_tdata <= {3'b000, cur.val, cur.idx, cur.rx};
          in_tuser <= cur.kind;
          nv = 1'b1;
          in_gap = gap_len();
        end
      end
      in_tvalid <= nv;
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    tx_byte_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_count++;
        if (answer_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected byte %h last %b", out_tdata, out_tlast);
        end else begin
          e = answer_bytes.pop_front();
          if (e.tx !== out_tdata || e.last !== out_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h/%b, got %h/%b", e.tx, e.last,
                       out_tdata, out_tlast);
          end
        end
      end
      if (!holdoff_done && out_count >= 60) begin
        holdoff_done = 1'b1;
        holdoff_left = 500;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = gap_len();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_gap = 0;
    out_gap = 0;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    mismatches = 0;
    out_count = 0;
    frames_seen = 0;
    idle_cycles = 0;
    sh_id = DEVICE_ID_RST;
    sh_id_next = DEVICE_ID_RST;
    sh_fill = 0;
    sh_start = 0;
    sh_end = 0;
    sh_end_seen = 1'b0;
    for (int i = 0; i < DEPTH; i++) sh_chunk[i] = 8'd0;
    for (int i = 0; i < NREGS; i++) begin
      sh_rw[i] = 16'd0;
      sh_ro[i] = 16'd0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset id
    push_raw(KIND_RO_LOAD, 8'h00, 5'd0, 16'hFFFF);
    push_raw(KIND_RO_LOAD, 8'hFF, 5'd31, 16'hA55A);
    push_frame(DEVICE_ID_RST, CMD_WRITE_RW, 8'd31, 8'hFF, 16'hFFFF);
    push_frame(DEVICE_ID_RST, CMD_WRITE_RW, 8'd200, 8'd0, 16'h1234);
    push_frame(DEVICE_ID_RST, CMD_READ_RO, 8'd0, 8'd0, 16'h0000);
    push_frame(DEVICE_ID_RST, CMD_READ_RO, 8'd20, 8'(MAXCNT), 16'h0000);
    push_frame(DEVICE_ID_RST, CMD_READ_RW, 8'd30, 8'(MAXCNT + 1), 16'h0000);
    push_frame(DEVICE_ID_RST, 8'h00, 8'd0, 8'd1, 16'h0000);
    push_frame(DEVICE_ID_RST, 8'hFF, 8'd0, 8'd1, 16'h0000);
    push_frame(8'd12, CMD_READ_RW, 8'd31, 8'd1, 16'h0000);
    // closing marker first: no end marker
    push_byte(SYM_END);
    push_end();
    // no start marker
    push_byte(DEVICE_ID_RST);
    push_byte(CMD_READ_RW);
    push_byte(SYM_END);
    push_end();
    // header running past the received fill reads stale bytes
    push_byte(SYM_START);
    push_byte(DEVICE_ID_RST);
    push_byte(CMD_READ_RW);
    push_byte(SYM_END);
    push_end();
    // header running past the buffer end, then overflow bytes dropped
    repeat (60) push_byte(8'h00);
    push_byte(SYM_START);
    push_byte(DEVICE_ID_RST);
    push_byte(CMD_WRITE_RW);
    push_byte(SYM_END);
    repeat (4) push_byte(SYM_START);
    push_end();
    push_raw(2'd3, 8'hFF, 5'd31, 16'hFFFF);
    random_phase(30);

    settle_and_config(8'd0);
    random_phase(25);
    settle_and_config(8'd255);
    random_phase(25);
    settle_and_config(8'($urandom));
    random_phase(25);

    while (pending_items.size() != 0 || in_tvalid || answer_bytes.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered four device ids, %0d answer frames and %0d answer bytes,", frames_seen,
             out_count);
    $display("with directed corner frames, random noise and one long receiver stall.");
    if (mismatches == 0 && answer_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[framed_register_access_slave_core.f]
hw/rtl/fras_pkg.sv
hw/rtl/fras_ram.sv
hw/rtl/fras_ctrl.sv
hw/rtl/fras_dp.sv
hw/rtl/framed_register_access_slave_core.sv
verif/tb.sv
